>>> rtl/mss_pkg.sv
// Shared constants, codes and types for the multi-section stack store.
// Depends on nothing; every other file of the block but mss_ram imports it.
package mss_pkg;

   // Default sizes, handed to the top-level parameters
   localparam int DEF_MAX_SECTIONS    = 16;
   localparam int DEF_POOL_ENTRIES    = 256;
   localparam int DEF_PACKAGE_ID_BITS = 16;

   // Fixed field widths
   localparam int SECTION_BITS = 8;
   localparam int COUNT_BITS   = 5;
   localparam int STATUS_BITS  = 2;

   typedef logic [STATUS_BITS-1:0] status_type;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_RANGE     = 2'd1;
   localparam status_type ST_EMPTY     = 2'd2;
   localparam status_type ST_POOL_FULL = 2'd3;

   localparam logic KIND_STORE    = 1'b0;
   localparam logic KIND_RETRIEVE = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // capture request, launch node read
      logic commit;     // apply update, load result register
      logic cfg_write;  // take new section count, empty every stack
   } mss_cmd_type;

endpackage

>>> rtl/mss_if.sv
// Channel interfaces for the multi-section stack store: request, response
// and configuration write. Depends on mss_pkg.
interface mss_req_if #(
   parameter int PACKAGE_ID_BITS = mss_pkg::DEF_PACKAGE_ID_BITS
);
   import mss_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [SECTION_BITS-1:0]    section;
   logic [PACKAGE_ID_BITS-1:0] package_id;

   modport source (output valid, kind, section, package_id, input ready);
   modport sink   (input valid, kind, section, package_id, output ready);
endinterface

interface mss_rsp_if #(
   parameter int PACKAGE_ID_BITS = mss_pkg::DEF_PACKAGE_ID_BITS
);
   import mss_pkg::*;
   logic                       valid;
   logic                       ready;
   status_type                 status;
   logic [PACKAGE_ID_BITS-1:0] package_out;
   logic                       section_empty;
   logic                       all_empty;

   modport source (output valid, status, package_out, section_empty, all_empty,
                   input ready);
   modport sink   (input valid, status, package_out, section_empty, all_empty,
                   output ready);
endinterface

interface mss_csr_if;
   import mss_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] section_count;

   modport source (output valid, section_count, input ready);
   modport sink   (input valid, section_count, output ready);
endinterface

>>> rtl/multi_section_stack_store_core.sv
// Top level of the multi-section stack store: joins controller and datapath
// to the channel interfaces. Depends on mss_pkg, mss_if, mss_ctrl, mss_datapath.
//
// One last-in-first-out stack of package identifiers per section, all
// stacks sharing one pool of POOL_ENTRIES linked nodes with a free list.
// A store request (kind 0) pushes package_id onto the addressed section, a
// retrieve request (kind 1) pops it. Every request gives exactly one
// response: status 0 ok, 1 section at or above the configured count (or
// MAX_SECTIONS), 2 retrieve from an empty section, 3 store with the pool
// exhausted (the push is dropped). package_out carries the popped identifier
// on a good retrieve and is 0 otherwise; section_empty and all_empty report
// the state after the request. For each request the accept
// cycle launches the read of the node memory (stack top or free-list head),
// and the commit step, once the response slot frees, applies the update with
// that registered read data and loads the response register. One request is
// in flight at a time; a new one is accepted while the previous response waits.
// Writing section_count over csr_ch empties every stack and frees the whole
// pool at once; there is no clearing pass after reset or after a write.
// Write it only while no request is in flight or its response undelivered.
module multi_section_stack_store_core #(
   parameter int MAX_SECTIONS    = mss_pkg::DEF_MAX_SECTIONS,
   parameter int POOL_ENTRIES    = mss_pkg::DEF_POOL_ENTRIES,
   parameter int PACKAGE_ID_BITS = mss_pkg::DEF_PACKAGE_ID_BITS
) (
   input logic        clock,
   input logic        reset,
   mss_req_if.sink    req_ch,
   mss_rsp_if.source  rsp_ch,
   mss_csr_if.sink    csr_ch
);
   import mss_pkg::*;

   mss_cmd_type cmd;

   // Sequence each request: accept, then commit when the response slot frees
   mss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .cmd       (cmd)
   );

   // Hold stack state, node memories and the response payload
   mss_datapath #(
      .MAX_SECTIONS    (MAX_SECTIONS),
      .POOL_ENTRIES    (POOL_ENTRIES),
      .PACKAGE_ID_BITS (PACKAGE_ID_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_section_count (csr_ch.section_count),
      .req_kind          (req_ch.kind),
      .req_section       (req_ch.section),
      .req_package_id    (req_ch.package_id),
      .rsp_status        (rsp_ch.status),
      .rsp_package_out   (rsp_ch.package_out),
      .rsp_section_empty (rsp_ch.section_empty),
      .rsp_all_empty     (rsp_ch.all_empty)
   );

endmodule

>>> rtl/mss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the node package and link stores.
module mss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/mss_ctrl.sv
// Controller of the multi-section stack store: request/response handshake
// and the two-step sequence per request. Depends on mss_pkg.
module mss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   output mss_pkg::mss_cmd_type cmd
);
   import mss_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = (state_ff == ST_IDLE);
   assign cmd.accept    = req_valid && req_ready;
   assign cmd.commit    = (state_ff == ST_EXEC) && out_free;
   assign cmd.cfg_write = csr_valid && csr_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EXEC)
      else $error("result appeared without an execute step");

endmodule

>>> rtl/mss_datapath.sv
// Datapath of the multi-section stack store: stack tops, free list, fresh
// counter, node memories and the result register. Depends on mss_pkg, mss_ram.
module mss_datapath #(
   parameter int MAX_SECTIONS    = mss_pkg::DEF_MAX_SECTIONS,
   parameter int POOL_ENTRIES    = mss_pkg::DEF_POOL_ENTRIES,
   parameter int PACKAGE_ID_BITS = mss_pkg::DEF_PACKAGE_ID_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mss_pkg::mss_cmd_type                cmd,
   input  logic [mss_pkg::COUNT_BITS-1:0]      csr_section_count,
   input  logic                                req_kind,
   input  logic [mss_pkg::SECTION_BITS-1:0]    req_section,
   input  logic [PACKAGE_ID_BITS-1:0]          req_package_id,
   output mss_pkg::status_type                 rsp_status,
   output logic [PACKAGE_ID_BITS-1:0]          rsp_package_out,
   output logic                                rsp_section_empty,
   output logic                                rsp_all_empty
);
   import mss_pkg::*;

   localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int SLOTS  = 1 << SEC_W;
   localparam int NODE_W = $clog2(POOL_ENTRIES);
   localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
   localparam logic [LINK_W-1:0]       NULL_LINK = LINK_W'(POOL_ENTRIES);
   localparam logic [SECTION_BITS:0]   MAX_SEC_V = (SECTION_BITS + 1)'(MAX_SECTIONS);

   logic [COUNT_BITS-1:0]      count_ff;
   logic                       kind_ff;
   logic [SECTION_BITS-1:0]    sec_ff;
   logic [PACKAGE_ID_BITS-1:0] pkg_ff;
   logic [NODE_W-1:0]          top_ff [SLOTS];
   logic [SLOTS-1:0]           nonempty_ff, nonempty_in;
   logic [LINK_W-1:0]          free_top_ff, free_top_in;
   logic [LINK_W-1:0]          fresh_ff, fresh_in;

   status_type                 status_ff, status_in;
   logic [PACKAGE_ID_BITS-1:0] pout_ff, pout_in;
   logic                       sec_empty_ff, sec_empty_in;
   logic                       all_empty_ff, all_empty_in;

   logic [SEC_W-1:0]           req_sidx, sidx;
   logic [NODE_W-1:0]          rd_addr, top_node, node;
   logic [LINK_W-1:0]          rd_next, next_wdata;
   logic [PACKAGE_ID_BITS-1:0] rd_pkg;
   logic                       in_range, pkg_we, next_we, top_we, got_node;
   logic [NODE_W-1:0]          wr_addr, top_wdata;

   // Launch the node read at accept: pop needs the top node, push the free head
   assign req_sidx = req_section[SEC_W-1:0];
   assign rd_addr  = (req_kind == KIND_RETRIEVE) ? top_ff[req_sidx]
                                                 : free_top_ff[NODE_W-1:0];

   mss_ram #(.WIDTH(PACKAGE_ID_BITS), .DEPTH(POOL_ENTRIES)) u_pkg_ram (
      .clock   (clock),
      .wr_en   (pkg_we),
      .wr_addr (wr_addr),
      .wr_data (pkg_ff),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (rd_pkg)
   );

   mss_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (wr_addr),
      .wr_data (next_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (rd_next)
   );

   assign sidx     = sec_ff[SEC_W-1:0];
   assign top_node = top_ff[sidx];
   assign in_range = ({1'b0, sec_ff} < MAX_SEC_V) &&
                     (sec_ff < SECTION_BITS'(count_ff));

   always_comb begin
      nonempty_in = nonempty_ff;
      free_top_in = free_top_ff;
      fresh_in    = fresh_ff;
      status_in   = ST_OK;
      pout_in     = '0;
      pkg_we      = 1'b0;
      next_we     = 1'b0;
      top_we      = 1'b0;
      wr_addr     = top_node;
      next_wdata  = free_top_ff;
      top_wdata   = top_node;
      got_node    = 1'b0;
      node        = '0;
      if (!in_range) begin
         status_in = ST_RANGE;
      end else if (kind_ff == KIND_STORE) begin
         if (free_top_ff != NULL_LINK) begin
            node        = free_top_ff[NODE_W-1:0];
            free_top_in = rd_next;
            got_node    = 1'b1;
         end else if (fresh_ff < NULL_LINK) begin
            node     = fresh_ff[NODE_W-1:0];
            fresh_in = fresh_ff + LINK_W'(1);
            got_node = 1'b1;
         end
         if (got_node) begin
            pkg_we            = 1'b1;
            next_we           = 1'b1;
            top_we            = 1'b1;
            wr_addr           = node;
            next_wdata        = nonempty_ff[sidx] ? LINK_W'(top_node) : NULL_LINK;
            top_wdata         = node;
            nonempty_in[sidx] = 1'b1;
         end else begin
            status_in = ST_POOL_FULL;
         end
      end else begin
         if (!nonempty_ff[sidx]) begin
            status_in = ST_EMPTY;
         end else begin
            pout_in = rd_pkg;
            if (rd_next == NULL_LINK) begin
               nonempty_in[sidx] = 1'b0;
            end else begin
               top_we    = 1'b1;
               top_wdata = rd_next[NODE_W-1:0];
            end
            // Return the popped node to the free list
            next_we     = 1'b1;
            wr_addr     = top_node;
            next_wdata  = free_top_ff;
            free_top_in = LINK_W'(top_node);
         end
      end
      sec_empty_in = !in_range || !nonempty_in[sidx];
      all_empty_in = ~|nonempty_in;
      pkg_we  = pkg_we && cmd.commit;
      next_we = next_we && cmd.commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         nonempty_ff <= '0;
         free_top_ff <= NULL_LINK;
         fresh_ff    <= '0;
      end else if (cmd.cfg_write) begin
         count_ff    <= csr_section_count;
         nonempty_ff <= '0;
         free_top_ff <= NULL_LINK;
         fresh_ff    <= '0;
      end else if (cmd.commit) begin
         nonempty_ff <= nonempty_in;
         free_top_ff <= free_top_in;
         fresh_ff    <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind;
         sec_ff  <= req_section;
         pkg_ff  <= req_package_id;
      end
      if (cmd.commit && top_we) begin
         top_ff[sidx] <= top_wdata;
      end
      if (cmd.commit) begin
         status_ff    <= status_in;
         pout_ff      <= pout_in;
         sec_empty_ff <= sec_empty_in;
         all_empty_ff <= all_empty_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_package_out   = pout_ff;
   assign rsp_section_empty = sec_empty_ff;
   assign rsp_all_empty     = all_empty_ff;

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= NULL_LINK)
      else $error("fresh counter ran past the pool");

   a_push_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && kind_ff == KIND_STORE && status_in == ST_OK
      |=> nonempty_ff[sidx])
      else $error("successful push left its section marked empty");

   a_empty_agree: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (!all_empty_ff || sec_empty_ff))
      else $error("all sections empty but addressed section is not");

endmodule

>>> verif/tb_multi_section_stack_store_core.sv
// Self-checking testbench for multi_section_stack_store_core: stimulus table, then random phases.
// Depends on mss_pkg, the channel interfaces in mss_if and the core itself.
module tb_multi_section_stack_store_core;
   import mss_pkg::*;

   localparam int MAX_SECTIONS = DEF_MAX_SECTIONS;
   localparam int POOL_ENTRIES = DEF_POOL_ENTRIES;
   localparam int ID_BITS      = DEF_PACKAGE_ID_BITS;
   localparam int LINK_BITS    = $clog2(POOL_ENTRIES) + 1;
   localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(POOL_ENTRIES);

   localparam int MAX_GAP       = 5;
   localparam int LONG_HOLD     = 60;      // receiver hold-off, long enough to back up the input
   localparam int SETTLE_CYCLES = 4;       // settling margin before a count write or the verdict
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DIRECTED_ROWS = 27;
   localparam int PHASES        = 7;

   // One response as the core should deliver it
   typedef struct {
      status_type         status;
      logic [ID_BITS-1:0] package_out;
      logic               section_empty;
      logic               all_empty;
   } stack_outcome_type;

   typedef enum logic {ROW_REQUEST, ROW_SECTION_COUNT} row_kind_type;

   // Stimulus table row: either a section-count write or a request. Where
   // typed is set, the outcome fields are the response to insist on;
   // otherwise the predictor supplies it.
   typedef struct {
      row_kind_type          row;
      logic [COUNT_BITS-1:0] count;
      logic                  kind;
      logic [SECTION_BITS-1:0] section;
      logic [ID_BITS-1:0]    package_id;
      bit                    typed;
      status_type            status;
      logic [ID_BITS-1:0]    package_out;
      logic                  section_empty;
      logic                  all_empty;
   } directed_row_type;

   // Random phase: optional count write, length, mix of operations and idling
   typedef struct {
      bit                    write_count;
      logic [COUNT_BITS-1:0] count;
      int                    items;
      int                    store_pct;
      int                    in_range_pct;
      bit                    gapless;
      bit                    long_hold;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mss_req_if req_ch ();
   mss_rsp_if rsp_ch ();
   mss_csr_if csr_ch ();

   multi_section_stack_store_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the store: one linked stack per section over a shared
   // node pool, a free list of returned nodes and a counter of untouched
   // nodes handed out in order.
   // ------------------------------------------------------------------
   int unsigned             live_sections;
   logic [LINK_BITS-1:0]    top_of_section [MAX_SECTIONS];
   logic [MAX_SECTIONS-1:0] section_busy;
   logic [ID_BITS-1:0]      id_of_node     [POOL_ENTRIES];
   logic [LINK_BITS-1:0]    link_of_node   [POOL_ENTRIES];
   logic [LINK_BITS-1:0]    free_head;
   logic [LINK_BITS-1:0]    nodes_handed_out;

   stack_outcome_type outcomes_due [$];

   int  failures       = 0;
   int  requests_sent  = 0;
   int  responses_seen = 0;
   int  count_writes   = 0;
   int  status_seen [4] = '{0, 0, 0, 0};
   int  cycle_count    = 0;
   bit  no_idle        = 1'b0;
   bit  hold_responses = 1'b0;

   // A count write empties every stack and returns the whole pool
   function automatic void load_section_count(input logic [COUNT_BITS-1:0] value);
      live_sections = (value < MAX_SECTIONS) ? value : MAX_SECTIONS;
      for (int i = 0; i < MAX_SECTIONS; i++) begin
         top_of_section[i] = NULL_LINK;
      end
      section_busy     = '0;
      free_head        = NULL_LINK;
      nodes_handed_out = '0;
   endfunction

   // Apply one request to the shadow store and return the response it earns
   function automatic stack_outcome_type apply_stack_op(input logic kind,
                                                        input logic [SECTION_BITS-1:0] section,
                                                        input logic [ID_BITS-1:0] package_id);
      stack_outcome_type    outcome;
      logic [LINK_BITS-1:0] node;
      int unsigned          sec;
      outcome.status        = ST_OK;
      outcome.package_out   = '0;
      outcome.section_empty = 1'b1;
      sec = 32'(section);
      if (sec >= live_sections) begin
         outcome.status = ST_RANGE;
      end else if (kind == KIND_STORE) begin
         // take a recycled node first, else the next untouched one
         node = NULL_LINK;
         if (free_head != NULL_LINK) begin
            node      = free_head;
            free_head = link_of_node[node];
         end else if (nodes_handed_out < POOL_ENTRIES) begin
            node             = nodes_handed_out;
            nodes_handed_out = nodes_handed_out + 1'b1;
         end
         if (node == NULL_LINK) begin
            outcome.status = ST_POOL_FULL;
         end else begin
            id_of_node[node]    = package_id;
            link_of_node[node]  = top_of_section[sec];
            top_of_section[sec] = node;
            section_busy[sec]   = 1'b1;
         end
         outcome.section_empty = !section_busy[sec];
      end else begin
         node = top_of_section[sec];
         if (node == NULL_LINK) begin
            outcome.status = ST_EMPTY;
         end else begin
            outcome.package_out = id_of_node[node];
            top_of_section[sec] = link_of_node[node];
            if (top_of_section[sec] == NULL_LINK) begin
               section_busy[sec] = 1'b0;
            end
            link_of_node[node] = free_head;
            free_head          = node;
         end
         outcome.section_empty = !section_busy[sec];
      end
      outcome.all_empty = 1'b1;
      for (int i = 0; i < live_sections; i++) begin
         if (section_busy[i]) begin
            outcome.all_empty = 1'b0;
         end
      end
      return outcome;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         failures++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Request side. Offer one request after a random gap and hold it until
   // the core takes it; predict its response at the accepting edge. Valid
   // stays high across back-to-back requests and drops for a gap, a count write or the drain.
   // ------------------------------------------------------------------
   task automatic offer_request(input logic kind, input logic [SECTION_BITS-1:0] section,
                                input logic [ID_BITS-1:0] package_id, input bit typed,
                                input stack_outcome_type typed_outcome);
      int unsigned       gap;
      stack_outcome_type predicted;
      gap = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.section    <= section;
      req_ch.package_id <= package_id;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // advance the shadow store even where the response is typed in
      predicted = apply_stack_op(kind, section, package_id);
      outcomes_due.push_back(typed ? typed_outcome : predicted);
      requests_sent++;
   endtask

   // Write the section count only once the core has gone quiet
   task automatic write_section_count(input logic [COUNT_BITS-1:0] value);
      req_ch.valid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid         <= 1'b1;
      csr_ch.section_count <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      load_section_count(value);
      count_writes++;
   endtask

   // ------------------------------------------------------------------
   // Stimulus table. Rows typed in are the obvious ones: everything out
   // of range after reset, the first push and pop at both ends of the
   // section range and of the identifier range, empty-section retrieves,
   // and the clamp of an oversize count to the number of sections. Pool
   // exhaustion needs a full pool, so the random phases reach it.
   // ------------------------------------------------------------------
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // after reset no section is in use
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd0,   16'hFFFF, 1'b1, ST_RANGE, 16'h0000, 1'b1, 1'b1},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd255, 16'h0000, 1'b1, ST_RANGE, 16'h0000, 1'b1, 1'b1},
      '{ROW_SECTION_COUNT, 5'd16, KIND_STORE, 8'd0, 16'h0, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd0,   16'hFFFF, 1'b1, ST_EMPTY, 16'h0000, 1'b1, 1'b1},
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd0,   16'hFFFF, 1'b1, ST_OK,    16'h0000, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd15,  16'h0000, 1'b1, ST_OK,    16'h0000, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd16,  16'h1234, 1'b1, ST_RANGE, 16'h0000, 1'b1, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd0,   16'h0000, 1'b1, ST_OK,    16'hFFFF, 1'b1, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd15,  16'hFFFF, 1'b1, ST_OK,    16'h0000, 1'b1, 1'b1},
      // stack order and reuse of a freed node
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd3,   16'hA5A5, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd3,   16'h5A5A, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd9,   16'h00FF, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd3,   16'h0000, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd3,   16'hFF00, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd3,   16'h0000, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd3,   16'h0000, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd3,   16'h0000, 1'b1, ST_EMPTY, 16'h0000, 1'b1, 1'b0},
      // oversize count clamps to the section total and empties every stack
      '{ROW_SECTION_COUNT, 5'd31, KIND_STORE, 8'd0, 16'h0, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd9,   16'h0000, 1'b1, ST_EMPTY, 16'h0000, 1'b1, 1'b1},
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd15,  16'h8001, 1'b1, ST_OK,    16'h0000, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd16,  16'h8001, 1'b1, ST_RANGE, 16'h0000, 1'b1, 1'b0},
      // a single section
      '{ROW_SECTION_COUNT, 5'd1, KIND_STORE, 8'd0, 16'h0, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd1,   16'h7FFE, 1'b1, ST_RANGE, 16'h0000, 1'b1, 1'b1},
      '{ROW_REQUEST, 5'd0, KIND_STORE,    8'd0,   16'h7FFE, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd128, 16'h0000, 1'b1, ST_RANGE, 16'h0000, 1'b1, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd0,   16'h0000, 1'b0, ST_OK, 16'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, 5'd0, KIND_RETRIEVE, 8'd0,   16'h0000, 1'b1, ST_EMPTY, 16'h0000, 1'b1, 1'b1}
   };

   // Random phases. The single-section phase is store-heavy so the pool
   // runs dry and stores get dropped; the phase after it keeps the state
   // and drains, so freed nodes are recycled through the free list.
   phase_type phases [PHASES] = '{
      '{1'b1, 5'd16, 130, 55, 85, 1'b0, 1'b1},
      '{1'b1, 5'd1,  360, 97, 95, 1'b0, 1'b0},
      '{1'b0, 5'd1,  200, 20, 95, 1'b1, 1'b0},
      '{1'b1, 5'd7,  130, 50, 85, 1'b0, 1'b0},
      '{1'b1, 5'd0,  25,  50, 0,  1'b0, 1'b0},
      '{1'b1, 5'd31, 130, 60, 85, 1'b1, 1'b0},
      '{1'b1, 5'd5,  120, 50, 80, 1'b0, 1'b0}
   };

   // ------------------------------------------------------------------
   // Response side: random ready gaps, one long hold-off on request, and
   // a field-by-field compare against the oldest outstanding prediction.
   // ------------------------------------------------------------------
   initial begin
      int unsigned       pause;
      stack_outcome_type want;
      wait (reset == 1'b0);
      forever begin
         if (hold_responses) begin
            // hold off long enough for the core to stall its request side
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_responses = 1'b0;
         end else begin
            pause = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
            if (pause > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (pause) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         responses_seen++;
         status_seen[rsp_ch.status]++;
         if (outcomes_due.size() == 0) begin
            $error("response with no request outstanding (status 0x%0h)", rsp_ch.status);
            failures++;
         end else begin
            want = outcomes_due.pop_front();
            check_field("status",        32'(want.status),        32'(rsp_ch.status));
            check_field("package_out",   32'(want.package_out),   32'(rsp_ch.package_out));
            check_field("section_empty", 32'(want.section_empty), 32'(rsp_ch.section_empty));
            check_field("all_empty",     32'(want.all_empty),     32'(rsp_ch.all_empty));
         end
      end
   end

   // Watchdog: drop the run if it overruns a generous cycle budget
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence: reset, stimulus table, random phases, drain, verdict.
   // ------------------------------------------------------------------
   initial begin
      stack_outcome_type       typed_outcome;
      logic                    kind;
      logic [SECTION_BITS-1:0] section;
      logic [ID_BITS-1:0]      package_id;

      req_ch.valid         = 1'b0;
      req_ch.kind          = KIND_STORE;
      req_ch.section       = '0;
      req_ch.package_id    = '0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.section_count = '0;
      load_section_count('0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].row == ROW_SECTION_COUNT) begin
            write_section_count(directed_rows[r].count);
         end else begin
            typed_outcome.status        = directed_rows[r].status;
            typed_outcome.package_out   = directed_rows[r].package_out;
            typed_outcome.section_empty = directed_rows[r].section_empty;
            typed_outcome.all_empty     = directed_rows[r].all_empty;
            offer_request(directed_rows[r].kind, directed_rows[r].section,
                          directed_rows[r].package_id, directed_rows[r].typed, typed_outcome);
         end
      end

      foreach (phases[p]) begin
         if (phases[p].write_count) begin
            write_section_count(phases[p].count);
         end
         no_idle = phases[p].gapless;
         if (phases[p].long_hold) begin
            hold_responses = 1'b1;
         end
         for (int i = 0; i < phases[p].items; i++) begin
            kind = ($urandom_range(99) < phases[p].store_pct) ? KIND_STORE : KIND_RETRIEVE;
            // mostly live sections, else anywhere in the byte range
            if (live_sections != 0 && $urandom_range(99) < phases[p].in_range_pct) begin
               section = SECTION_BITS'($urandom_range(live_sections - 1, 0));
            end else begin
               section = SECTION_BITS'($urandom_range(255, 0));
            end
            package_id = ID_BITS'($urandom);
            offer_request(kind, section, package_id, 1'b0, typed_outcome);
         end
      end

      // drop valid, drain the outstanding responses, then let the core settle
      req_ch.valid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses across %0d section-count writes.",
               requests_sent, responses_seen, count_writes);
      $display("Statuses seen: ok %0d, out of range %0d, empty %0d, pool full %0d.",
               status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_EMPTY],
               status_seen[ST_POOL_FULL]);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/mss_pkg.sv
rtl/mss_if.sv
rtl/mss_ram.sv
rtl/mss_ctrl.sv
rtl/mss_datapath.sv
rtl/multi_section_stack_store_core.sv
verif/tb_multi_section_stack_store_core.sv
